/* rtl/shgb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shgb_pkg: shared types and constants for the spatial hash grid
// Operation codes, config indexes, sizes, sequencer states and divider types.
// ----------------------------------------------------------------------------
package shgb_pkg;

    localparam int MAX_CELLS       = 1024;
    localparam int BUCKET_CAPACITY = 16;
    localparam int ID_BITS         = 10;
    localparam int CELL_BITS       = $clog2(MAX_CELLS);
    localparam int SLOT_BITS       = $clog2(BUCKET_CAPACITY);
    localparam int FILL_BITS       = $clog2(BUCKET_CAPACITY + 1);
    localparam int MEM_BITS        = CELL_BITS + SLOT_BITS;
    localparam int CFG_BITS        = 16;
    localparam int CS_BITS         = 11;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_REG   = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_CELL   = 2'd2,
        CFG_NONE   = 2'd3
    } cfg_idx_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVW,
        ST_DIVH,
        ST_DIVX,
        ST_DIVY,
        ST_MUL,
        ST_CELL,
        ST_CLEAR,
        ST_REGRD,
        ST_REGWR,
        ST_QRD,
        ST_QMEM,
        ST_QOUT,
        ST_ACK,
        ST_INIT
    } state_t;

    // divider command and status
    typedef struct packed {
        logic               start;
        logic signed [17:0] dividend;
    } div_cmd_t;

    typedef struct packed {
        logic               done;
        logic signed [17:0] quotient;
    } div_sts_t;

endpackage

/* rtl/shgb_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shgb_divider: shared serial floor divider
// Restoring divider, one quotient bit per cycle, floor rounding for
// negative dividends.
// ----------------------------------------------------------------------------
module shgb_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  shgb_pkg::div_cmd_t            cmd,
    input  logic [shgb_pkg::CS_BITS-1:0]  divisor,
    output shgb_pkg::div_sts_t            sts
);
    import shgb_pkg::*;

    logic [4:0]            cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  neg_reg, neg_next;
    logic [17:0]           quo_reg, quo_next;
    logic [CS_BITS:0]      rem_reg, rem_next;
    logic [CS_BITS:0]      trial;
    logic [CS_BITS:0]      dsr;
    logic [17:0]           mag;
    logic                  done_reg, done_next;
    logic signed [17:0]    res_reg, res_next;

    assign dsr = (divisor == '0) ? {{CS_BITS{1'b0}}, 1'b1} : {1'b0, divisor};
    assign mag = cmd.dividend[17] ? 18'(-cmd.dividend) : 18'(cmd.dividend);
    assign trial = {rem_reg[CS_BITS-1:0], quo_reg[17]};

    // one quotient bit per cycle
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            neg_next  = cmd.dividend[17];
            quo_next  = mag;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= dsr)
            begin
                rem_next = trial - dsr;
                quo_next = {quo_reg[16:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[16:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd17)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg)
                    res_next = (rem_next != '0) ? -$signed(quo_next) - 18'sd1
                                                : -$signed(quo_next);
                else
                    res_next = $signed(quo_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign sts.done     = done_reg;
    assign sts.quotient = res_reg;

endmodule

/* rtl/spatial_hash_grid_binning_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_hash_grid_binning_top: uniform grid spatial hash broad phase
// Bins object boxes into grid buckets, answers neighbour queries and clears.
// ----------------------------------------------------------------------------
// Usage: an input beat (func, object_id, box) is taken on in_valid/in_ready;
// result beats leave on out_valid/out_ready. Configuration is written through
// cfg_we/cfg_index/cfg_data while the block is idle.
// One item at a time: in_ready is high only in the idle state.
// A register or query first runs six divisions on one shared serial divider
// (grid columns, grid rows, two x and two y corner coordinates), then the
// multiply step and the corner step, which checks each of the four corners.
// Register: a fill read and a write per covered cell, then an ack beat.
// Query: fill and member reads per covered cell, an output step per found
// id; each id is held one step so the final one carries last, and it leaves
// in the ack step.
// Clear: a sweep over all 1024 entries of the fill table, then one ack beat.
// The same sweep runs after reset with in_ready low and sends no beat.
// A stalled receiver holds the result register and the sequencer waits on it;
// no beat is lost.
// ----------------------------------------------------------------------------
module spatial_hash_grid_binning_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [shgb_pkg::CFG_BITS-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    func,
    input  logic [9:0]                    object_id,
    input  logic signed [15:0]            pos_x,
    input  logic signed [15:0]            pos_y,
    input  logic [15:0]                   box_width,
    input  logic [15:0]                   box_height,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [9:0]                    neighbour_id,
    output logic                          found,
    output logic                          overflow,
    output logic                          last
);
    import shgb_pkg::*;

    // configuration
    logic [15:0]        width_reg, height_reg;
    logic [CS_BITS-1:0] cell_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 16'd640;
            height_reg <= 16'd480;
            cell_reg   <= 11'd32;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_CELL:   cell_reg   <= cfg_data[CS_BITS-1:0];
                default:    ;
            endcase
        end
    end

    // memories
    logic [FILL_BITS-1:0] fill_mem [MAX_CELLS];
    logic [ID_BITS-1:0]   member_mem [MAX_CELLS*BUCKET_CAPACITY];
    logic [FILL_BITS-1:0] fill_rd_reg;
    logic [ID_BITS-1:0]   mem_rd_reg;

    state_t state_reg, state_next;
    func_t               op_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic signed [17:0]  x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [17:0]  cx0_reg, cx1_reg, cy0_reg, cy1_reg;
    logic [16:0]         cols_reg, rows_reg;
    logic [33:0]         size_reg;
    logic signed [35:0]  row0_reg, row1_reg;
    logic [1:0]          corner_reg;
    logic [2:0]          ncell_reg;
    logic signed [36:0]  seen_reg [4];
    logic [CELL_BITS-1:0] cells_reg [4];
    logic [1:0]          cidx_reg;
    logic [SLOT_BITS:0]  slot_reg;
    logic [CELL_BITS:0]  sweep_reg;
    logic                ovf_reg;
    logic [6:0]          emitted_reg;
    logic [ID_BITS-1:0]  pend_reg;
    logic                div_wait_reg;

    div_cmd_t dcmd;
    div_sts_t dsts;

    shgb_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (dcmd),
        .divisor (cell_reg),
        .sts     (dsts)
    );

    // current corner cell
    logic signed [36:0] cur_cell;
    logic signed [17:0] ccx;
    logic signed [35:0] crow;
    logic               dup, inrange;
    logic [CELL_BITS-1:0] cur_c;
    always_comb
    begin
        ccx  = (corner_reg == 2'd0 || corner_reg == 2'd3) ? cx0_reg : cx1_reg;
        crow = (corner_reg == 2'd0 || corner_reg == 2'd1) ? row0_reg : row1_reg;
        cur_cell = 37'(ccx) + 37'(crow);
        dup = 1'b0;
        for (int j = 0; j < 4; j++)
            if (j < int'(corner_reg) && seen_reg[j] == cur_cell)
                dup = 1'b1;
        inrange = !cur_cell[36] && (cur_cell < $signed({3'b0, size_reg}))
                  && (cur_cell < 37'(MAX_CELLS));
        cur_c = cur_cell[CELL_BITS-1:0];
    end

    logic [CELL_BITS-1:0] act_c;
    assign act_c = cells_reg[cidx_reg];

    // output register
    logic ovalid_reg;
    logic [ID_BITS-1:0] oid_reg;
    logic ofound_reg, oovf_reg, olast_reg;
    logic out_free;
    logic oload;
    assign out_free = !ovalid_reg || out_ready;
    assign oload    = out_free && (state_reg == ST_ACK ||
                                   (state_reg == ST_QOUT && emitted_reg != '0));

    // fill count of current bucket
    logic [SLOT_BITS:0] fcap;
    assign fcap = 5'(fill_rd_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    unique case (func_t'(func))
                        FUNC_CLEAR: state_next = ST_CLEAR;
                        FUNC_REG, FUNC_QUERY: state_next = ST_DIVW;
                        default: state_next = ST_ACK;
                    endcase
                end
            ST_DIVW: if (dsts.done && div_wait_reg) state_next = ST_DIVH;
            ST_DIVH: if (dsts.done && div_wait_reg) state_next = ST_DIVX;
            ST_DIVX: if (dsts.done && div_wait_reg && corner_reg[0]) state_next = ST_DIVY;
            ST_DIVY: if (dsts.done && div_wait_reg && corner_reg[0]) state_next = ST_MUL;
            ST_MUL:  state_next = ST_CELL;
            ST_CELL:
                if (corner_reg == 2'd3)
                begin
                    if (op_reg == FUNC_REG)
                        state_next = (ncell_reg != 0 || (!dup && inrange))
                                     ? ST_REGRD : ST_ACK;
                    else
                        state_next = (ncell_reg != 0 || (!dup && inrange))
                                     ? ST_QRD : ST_ACK;
                end
            ST_CLEAR: if (sweep_reg[CELL_BITS]) state_next = ST_ACK;
            ST_INIT:  if (sweep_reg[CELL_BITS]) state_next = ST_IDLE;
            ST_REGRD: state_next = ST_REGWR;
            ST_REGWR: if (cidx_reg == 2'(ncell_reg - 3'd1)) state_next = ST_ACK;
                      else state_next = ST_REGRD;
            ST_QRD:   state_next = ST_QMEM;
            ST_QMEM:
                if (slot_reg >= fcap)
                begin
                    if (cidx_reg == 2'd0)
                        state_next = ST_ACK;
                    else
                        state_next = ST_QRD;
                end
                else
                    state_next = ST_QOUT;
            ST_QOUT: if (out_free || emitted_reg == '0) state_next = ST_QMEM;
            ST_ACK:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            sweep_reg    <= '0;
            ovalid_reg   <= 1'b0;
            div_wait_reg <= 1'b0;
            corner_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (oload)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    sweep_reg    <= '0;
                    corner_reg   <= '0;
                    div_wait_reg <= 1'b0;
                end
                ST_DIVW, ST_DIVH:
                begin
                    div_wait_reg <= !(dsts.done && div_wait_reg);
                    if (dsts.done && div_wait_reg)
                    begin
                        if (state_reg == ST_DIVW)
                            cols_reg <= 17'(dsts.quotient) + 17'd1;
                        else
                            rows_reg <= 17'(dsts.quotient) + 17'd1;
                    end
                end
                ST_DIVX, ST_DIVY:
                begin
                    div_wait_reg <= !(dsts.done && div_wait_reg);
                    if (dsts.done && div_wait_reg)
                    begin
                        corner_reg <= corner_reg[0] ? 2'd0 : 2'd1;
                        if (state_reg == ST_DIVX)
                        begin
                            if (corner_reg[0]) cx1_reg <= dsts.quotient;
                            else               cx0_reg <= dsts.quotient;
                        end
                        else
                        begin
                            if (corner_reg[0]) cy1_reg <= dsts.quotient;
                            else               cy0_reg <= dsts.quotient;
                        end
                    end
                end
                ST_MUL:
                begin
                    row0_reg   <= 36'(cy0_reg * $signed({1'b0, cols_reg}));
                    row1_reg   <= 36'(cy1_reg * $signed({1'b0, cols_reg}));
                    size_reg   <= cols_reg * rows_reg;
                    corner_reg <= '0;
                    ncell_reg  <= '0;
                    ovf_reg    <= 1'b0;
                    emitted_reg <= '0;
                end
                ST_CELL:
                begin
                    seen_reg[corner_reg] <= cur_cell;
                    if (!dup && inrange)
                    begin
                        cells_reg[ncell_reg[1:0]] <= cur_c;
                        ncell_reg <= ncell_reg + 3'd1;
                    end
                    corner_reg <= corner_reg + 2'd1;
                    if (op_reg == FUNC_REG)
                        cidx_reg <= '0;
                    else
                        cidx_reg <= 2'(ncell_reg + ((!dup && inrange) ? 3'd1 : 3'd0) - 3'd1);
                end
                ST_CLEAR, ST_INIT: sweep_reg <= sweep_reg + 1'b1;
                ST_REGWR:
                begin
                    if (fill_rd_reg[SLOT_BITS])
                        ovf_reg <= 1'b1;
                    cidx_reg <= cidx_reg + 2'd1;
                end
                ST_QRD: slot_reg <= '0;
                ST_QMEM:
                    if (slot_reg >= fcap && cidx_reg != 2'd0)
                        cidx_reg <= cidx_reg - 2'd1;
                // hold each id one step so the final one can carry last
                ST_QOUT:
                    if (out_free || emitted_reg == '0)
                    begin
                        if (oload)
                        begin
                            oid_reg    <= pend_reg;
                            ofound_reg <= 1'b1;
                            oovf_reg   <= 1'b0;
                            olast_reg  <= 1'b0;
                        end
                        pend_reg    <= mem_rd_reg;
                        slot_reg    <= slot_reg + 1'b1;
                        emitted_reg <= emitted_reg + 7'd1;
                    end
                ST_ACK:
                    if (out_free)
                    begin
                        oid_reg    <= (op_reg == FUNC_QUERY && emitted_reg != '0)
                                      ? pend_reg : '0;
                        ofound_reg <= (op_reg == FUNC_QUERY) && (emitted_reg != '0);
                        oovf_reg   <= (op_reg == FUNC_REG) && ovf_reg;
                        olast_reg  <= 1'b1;
                    end
                default: ;
            endcase
        end
    end

    // item capture and divider commands
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            op_reg <= func_t'(func);
            id_reg <= object_id;
            x0_reg <= 18'(pos_x);
            y0_reg <= 18'(pos_y);
            x1_reg <= 18'(pos_x) + $signed({2'b0, box_width});
            y1_reg <= 18'(pos_y) + $signed({2'b0, box_height});
        end
    end

    always_comb
    begin
        dcmd.start    = 1'b0;
        dcmd.dividend = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                dcmd.start    = 1'b0;
            end
            ST_DIVW, ST_DIVH, ST_DIVX, ST_DIVY:
            begin
                dcmd.start = !div_wait_reg;
                unique case (state_reg)
                    ST_DIVW: dcmd.dividend = 18'({2'b0, width_reg});
                    ST_DIVH: dcmd.dividend = 18'({2'b0, height_reg});
                    ST_DIVX: dcmd.dividend = corner_reg[0] ? x1_reg : x0_reg;
                    default: dcmd.dividend = corner_reg[0] ? y1_reg : y0_reg;
                endcase
            end
            default: ;
        endcase
    end

    // memory ports
    logic [MEM_BITS-1:0] raddr;
    assign raddr = {act_c, slot_reg[SLOT_BITS-1:0]};

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_CLEAR || state_reg == ST_INIT) && !sweep_reg[CELL_BITS])
            fill_mem[sweep_reg[CELL_BITS-1:0]] <= '0;
        else if (state_reg == ST_REGWR && !fill_rd_reg[SLOT_BITS])
            fill_mem[act_c] <= fill_rd_reg + 1'b1;
        fill_rd_reg <= fill_mem[act_c];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_REGWR && !fill_rd_reg[SLOT_BITS])
            member_mem[{act_c, fill_rd_reg[SLOT_BITS-1:0]}] <= id_reg;
        mem_rd_reg <= member_mem[raddr];
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = ovalid_reg;
    assign neighbour_id = oid_reg;
    assign found        = ofound_reg;
    assign overflow     = oovf_reg;
    assign last         = olast_reg;

endmodule

/* rtl/shgb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shgb_checker: port level checks for the spatial hash grid
// Watches the channels of the top level.
// ----------------------------------------------------------------------------
module shgb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [9:0] neighbour_id,
    input logic       found,
    input logic       overflow,
    input logic       last
);
    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(neighbour_id) && $stable(last))
        else $error("result beat changed under stall");

    // no new item while a non-final result beat is pending
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input accepted mid item");

    // a non-found beat always closes the item
    a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> last)
        else $error("ack beat without last");

    // overflow and found never together
    a_ovf_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(found && overflow))
        else $error("overflow on a found beat");

endmodule

bind spatial_hash_grid_binning_top shgb_checker u_chk (.*);
